[rtl/rswt_pkg.sv]
// ----------------------------------------------------------------------------
// rswt_pkg
// Shared types, codes and helpers for the receive sequence window tracker.
// ----------------------------------------------------------------------------
package rswt_pkg;

    localparam int SEQ_BITS_DEF  = 16;
    localparam int PORT_SEQ_BITS = 16;
    localparam int WORD_BITS     = 32;
    localparam int OFF_BITS      = 5;
    localparam int RUN_BITS      = OFF_BITS + 1;

    typedef enum logic [2:0] {
        V_NEW     = 3'd0,
        V_DUP     = 3'd1,
        V_OLD     = 3'd2,
        V_DROP    = 3'd3,
        V_NOSTART = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLASSIFY,
        ST_MARK,
        ST_ADV_RD,
        ST_ADV,
        ST_OUT
    } state_t;

    // Number of consecutive ones starting at bit 0.
    function automatic logic [RUN_BITS-1:0] trail_ones(input logic [WORD_BITS-1:0] w);
        logic [RUN_BITS-1:0] n;
        n = RUN_BITS'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                n = RUN_BITS'(i);
            end
        end
        return n;
    endfunction

endpackage

[rtl/receive_sequence_window_tracker_unit.sv]
// ----------------------------------------------------------------------------
// receive_sequence_window_tracker_unit
// Receive-side sliding window with a reorder bitmap and cumulative acks.
// ----------------------------------------------------------------------------
// One result per packet. After reset the bitmap memory is swept clear, all
// 2^(SEQ_BITS-5) words (2048 at the default width), one 32-bit word per
// cycle; no packet is taken during the sweep. A packet is then handled one
// at a time: a not-started packet goes straight to output, an old or dropped
// packet is classified first, and an in-window packet is classified, then
// marked, plus a read and a write-back state for each further bitmap word
// the expected sequence walks into while advancing. Each word is read
// through the registered read port, then modified and written back. A
// result may wait in the output register while the next packet is accepted.
module receive_sequence_window_tracker_unit
    import rswt_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PORT_SEQ_BITS-1:0] s_seq_number,
    input  logic                     s_start_flag,
    input  logic                     s_finish_flag,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_verdict,
    output logic                     m_ack_valid,
    output logic [PORT_SEQ_BITS-1:0] m_ack_number,
    output logic [PORT_SEQ_BITS-1:0] m_echoed_seq,
    output logic [PORT_SEQ_BITS-1:0] m_highest_seen,
    output logic                     m_shutdown_seen
);

    localparam int ADDR_BITS = SEQ_BITS - OFF_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;

    // bitmap memory
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [WORD_BITS-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                 started_reg, started_next;
    logic [SEQ_BITS-1:0]  exp_reg, exp_next;
    logic [SEQ_BITS-1:0]  max_reg, max_next;
    logic [SEQ_BITS-1:0]  seq_reg, seq_next;
    logic                 upd_max_reg, upd_max_next;
    logic                 adv_reg, adv_next;
    verdict_t             verdict_reg, verdict_next;
    logic                 ack_valid_reg, ack_valid_next;
    logic                 shut_reg, shut_next;

    logic                     m_valid_reg, m_valid_next;
    verdict_t                 m_verdict_reg, m_verdict_next;
    logic                     m_ack_valid_reg, m_ack_valid_next;
    logic [PORT_SEQ_BITS-1:0] m_ack_number_reg, m_ack_number_next;
    logic [PORT_SEQ_BITS-1:0] m_echoed_seq_reg, m_echoed_seq_next;
    logic [PORT_SEQ_BITS-1:0] m_highest_reg, m_highest_next;
    logic                     m_shut_reg, m_shut_next;

    // classify / advance datapath
    logic [SEQ_BITS-1:0]    pkt_dist, max_dist;
    logic [OFF_BITS-1:0]    seq_off, exp_off;
    logic [WORD_BITS-1:0]   mark_word, adv_word, adv_shift, adv_clr, adv_result;
    logic [RUN_BITS-1:0]    run_len;
    logic [RUN_BITS-1:0]    run_end;
    logic [2*WORD_BITS-1:0] run_mask;
    logic                   word_done;

    assign seq_off    = seq_reg[OFF_BITS-1:0];
    assign exp_off    = exp_reg[OFF_BITS-1:0];
    assign pkt_dist   = seq_reg - exp_reg;
    assign max_dist   = max_reg - exp_reg;
    assign mark_word  = rd_data_reg | (WORD_BITS'(1) << seq_off);
    assign adv_word   = (state_reg == ST_MARK) ? mark_word : rd_data_reg;
    assign adv_shift  = adv_word >> exp_off;
    assign run_len    = trail_ones(adv_shift);
    assign run_mask   = ~({(2*WORD_BITS){1'b1}} << run_len);
    assign adv_clr    = run_mask[WORD_BITS-1:0] << exp_off;
    assign adv_result = adv_word & ~adv_clr;
    assign run_end    = RUN_BITS'(exp_off) + run_len;
    assign word_done  = (run_end == RUN_BITS'(WORD_BITS));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            started_reg <= 1'b0;
            exp_reg     <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            started_reg <= started_next;
            exp_reg     <= exp_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg          <= seq_next;
        upd_max_reg      <= upd_max_next;
        adv_reg          <= adv_next;
        verdict_reg      <= verdict_next;
        ack_valid_reg    <= ack_valid_next;
        shut_reg         <= shut_next;
        m_verdict_reg    <= m_verdict_next;
        m_ack_valid_reg  <= m_ack_valid_next;
        m_ack_number_reg <= m_ack_number_next;
        m_echoed_seq_reg <= m_echoed_seq_next;
        m_highest_reg    <= m_highest_next;
        m_shut_reg       <= m_shut_next;
    end

    always_comb begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        started_next      = started_reg;
        exp_next          = exp_reg;
        max_next          = max_reg;
        seq_next          = seq_reg;
        upd_max_next      = upd_max_reg;
        adv_next          = adv_reg;
        verdict_next      = verdict_reg;
        ack_valid_next    = ack_valid_reg;
        shut_next         = shut_reg;
        m_valid_next      = m_valid_reg;
        m_verdict_next    = m_verdict_reg;
        m_ack_valid_next  = m_ack_valid_reg;
        m_ack_number_next = m_ack_number_reg;
        m_echoed_seq_next = m_echoed_seq_reg;
        m_highest_next    = m_highest_reg;
        m_shut_next       = m_shut_reg;
        mem_we            = 1'b0;
        mem_waddr         = exp_reg[SEQ_BITS-1:OFF_BITS];
        mem_wdata         = adv_result;
        mem_re            = 1'b0;
        mem_raddr         = exp_reg[SEQ_BITS-1:OFF_BITS];
        s_ready           = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {ADDR_BITS{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    seq_next       = SEQ_BITS'(s_seq_number);
                    ack_valid_next = 1'b0;
                    if (!started_reg && !s_start_flag) begin
                        verdict_next = V_NOSTART;
                        shut_next    = 1'b0;
                        state_next   = ST_OUT;
                    end else begin
                        started_next = 1'b1;
                        shut_next    = s_finish_flag;
                        state_next   = ST_CLASSIFY;
                    end
                end
            end
            ST_CLASSIFY: begin
                if (!pkt_dist[SEQ_BITS-1]) begin
                    mem_re       = 1'b1;
                    mem_raddr    = seq_reg[SEQ_BITS-1:OFF_BITS];
                    upd_max_next = (pkt_dist > max_dist);
                    adv_next     = (pkt_dist == '0);
                    state_next   = ST_MARK;
                end else if (pkt_dist[SEQ_BITS-2] && (|pkt_dist[SEQ_BITS-3:0])) begin
                    verdict_next   = V_OLD;
                    ack_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    verdict_next = V_DROP;
                    state_next   = ST_OUT;
                end
            end
            ST_MARK: begin
                verdict_next   = rd_data_reg[seq_off] ? V_DUP : V_NEW;
                ack_valid_next = 1'b1;
                if (upd_max_reg) begin
                    max_next = seq_reg;
                end
                mem_we    = 1'b1;
                mem_waddr = seq_reg[SEQ_BITS-1:OFF_BITS];
                if (adv_reg) begin
                    mem_wdata  = adv_result;
                    exp_next   = exp_reg + SEQ_BITS'(run_len);
                    state_next = word_done ? ST_ADV_RD : ST_OUT;
                end else begin
                    mem_wdata  = mark_word;
                    state_next = ST_OUT;
                end
            end
            ST_ADV_RD: begin
                mem_re     = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                mem_we     = 1'b1;
                exp_next   = exp_reg + SEQ_BITS'(run_len);
                state_next = word_done ? ST_ADV_RD : ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_verdict_next    = verdict_reg;
                    m_ack_valid_next  = ack_valid_reg;
                    m_ack_number_next = ack_valid_reg ?
                                        PORT_SEQ_BITS'(exp_reg - 1'b1) : '0;
                    m_echoed_seq_next = ack_valid_reg ? PORT_SEQ_BITS'(seq_reg) : '0;
                    m_highest_next    = PORT_SEQ_BITS'(max_reg);
                    m_shut_next       = shut_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_verdict       = m_verdict_reg;
    assign m_ack_valid     = m_ack_valid_reg;
    assign m_ack_number    = m_ack_number_reg;
    assign m_echoed_seq    = m_echoed_seq_reg;
    assign m_highest_seen  = m_highest_reg;
    assign m_shutdown_seen = m_shut_reg;

    // acks go out exactly for new, duplicate and re-acked packets
    a_ack_by_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ack_valid == (m_verdict == V_NEW || m_verdict == V_DUP ||
                                     m_verdict == V_OLD)))
        else $error("ack_valid does not match verdict");

    // expected sequence moves only while marking or walking the bitmap
    a_exp_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (exp_reg != $past(exp_reg)) |->
            ($past(state_reg) == ST_MARK || $past(state_reg) == ST_ADV))
        else $error("expected sequence changed outside advance");

    // a not-started result never reports shutdown or an ack
    a_nostart_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_verdict == V_NOSTART) |-> (!m_shutdown_seen && !m_ack_valid))
        else $error("not-started result carries shutdown or ack");

endmodule
